// ----- design/psbnc_pkg.sv -----
// shared constants, codes and types of the nearest palette colour core
package psbnc_pkg;

    // palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int COMP_W      = 6;
    localparam int NUM_COMP    = 3;
    localparam int COLOR_W     = NUM_COMP * COMP_W;
    localparam int IDX_W       = 8;

    // register and field widths
    localparam int SHADE_W    = 9;
    localparam int RATIO_W    = 9;
    localparam int WEIGHT_W   = 8;
    localparam int DIST_W     = 22;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // shade scale and blend arithmetic
    localparam int SCALE_FRAC   = 16;
    localparam int SCALE_W      = SCALE_FRAC + 1;
    localparam int SHADE_ROUND  = 1 << (SCALE_FRAC - 1);
    localparam int SHADE_PROD_W = COMP_W + SCALE_W;
    localparam int BLEND_FRAC   = 8;
    localparam int BLEND_ONE    = 1 << BLEND_FRAC;
    localparam int BLEND_HALF   = 1 << (BLEND_FRAC - 1);
    localparam int BLEND_PROD_W = COMP_W + RATIO_W + 1;

    // radix-4 divider sizing
    localparam int DIV_W      = SHADE_W + SCALE_FRAC;
    localparam int DIV_PAD_W  = DIV_W + (DIV_W % 2);
    localparam int DIV_CYCLES = DIV_PAD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SHADES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_RATIO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 3'd4;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RGB   = 2'd1,
        ACT_SHADE = 2'd2,
        ACT_BLEND = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_MIX,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        action_t          action;
        logic [IDX_W-1:0] first_color;
        logic [IDX_W-1:0] second_color;
        logic [7:0]       shade;
        comp_t            red;
        comp_t            green;
        comp_t            blue;
    } item_t;

    typedef struct packed {
        action_t           done_action;
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] best_distance;
    } result_t;

    // one palette entry travelling down the cell row
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [PAL_AW-1:0]          index;
        comp_t [NUM_COMP-1:0]       comps;
        logic [DIST_W-1:0]          sum;
    } flow_t;

    typedef struct packed {
        logic               start;
        logic [SHADE_W-1:0] numer;
        logic [SHADE_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] quot;
    } div_resp_t;

endpackage

// ----- design/psbnc_ram.sv -----
// palette memory: one write port, two registered read ports
module psbnc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 18,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a_reg <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/psbnc_div.sv -----
// shade scale divider: ((n - s) << 16) / n, two quotient bits a cycle
module psbnc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psbnc_pkg::div_req_t  req,
    output psbnc_pkg::div_resp_t resp
);
    import psbnc_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SHADE_W-1:0]   rem_reg, rem_next;
    logic [SHADE_W-1:0]   denom_reg, denom_next;
    logic [DIV_PAD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_PAD_W-1:0] quot_reg, quot_next;

    logic [SHADE_W-1:0]   rem_v;
    logic [DIV_PAD_W-1:0] dvd_v;
    logic [DIV_PAD_W-1:0] quot_v;
    logic [SHADE_W:0]     trial;

    // two restoring steps
    always_comb
    begin
        rem_v  = rem_reg;
        dvd_v  = dvd_reg;
        quot_v = quot_reg;
        trial  = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_v, dvd_v[DIV_PAD_W-1]};
            dvd_v = {dvd_v[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, denom_reg})
            begin
                rem_v  = SHADE_W'(trial - {1'b0, denom_reg});
                quot_v = {quot_v[DIV_PAD_W-2:0], 1'b1};
            end
            else
            begin
                rem_v  = trial[SHADE_W-1:0];
                quot_v = {quot_v[DIV_PAD_W-2:0], 1'b0};
            end
        end
    end

    // sequencing
    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        if (req.start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            denom_next = req.denom;
            dvd_next   = DIV_PAD_W'({req.numer, SCALE_FRAC'(0)});
            quot_next  = '0;
        end
        else if (run_reg)
        begin
            rem_next  = rem_v;
            dvd_next  = dvd_v;
            quot_next = quot_v;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        dvd_reg   <= dvd_next;
        quot_reg  <= quot_next;
    end

    assign resp.done = done_reg;
    assign resp.quot = quot_reg[SCALE_W-1:0];

endmodule

// ----- design/psbnc_cell.sv -----
// distance cell: adds one weighted squared component difference
module psbnc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  psbnc_pkg::comp_t                 tgt,
    input  logic [psbnc_pkg::WEIGHT_W-1:0]   weight,
    input  psbnc_pkg::flow_t                 flow_in,
    output psbnc_pkg::flow_t                 flow_out
);
    import psbnc_pkg::*;

    comp_t                      diff;
    logic [SQ_W-1:0]            sq_next, sq_reg;
    logic [WEIGHT_W+SQ_W-1:0]   term;
    flow_t                      mid_reg;
    flow_t                      out_next, out_reg;

    // absolute difference and its square
    always_comb
    begin
        if (flow_in.comps[0] > tgt)
        begin
            diff = flow_in.comps[0] - tgt;
        end
        else
        begin
            diff = tgt - flow_in.comps[0];
        end
        sq_next = SQ_W'(diff) * SQ_W'(diff);
    end

    // weight, accumulate, rotate the next component to the front
    always_comb
    begin
        term     = (WEIGHT_W + SQ_W)'(weight) * (WEIGHT_W + SQ_W)'(sq_reg);
        out_next = mid_reg;
        out_next.sum = mid_reg.sum + DIST_W'(term);
        out_next.comps[NUM_COMP-1] = mid_reg.comps[0];
        for (int k = 0; k < NUM_COMP - 1; k++)
        begin
            out_next.comps[k] = mid_reg.comps[k+1];
        end
    end

    // two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            mid_reg <= flow_in;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign flow_out = out_reg;

endmodule

// ----- design/palette_shade_blend_nearest_color_core.sv -----
// nearest palette colour core: palette store, target setup, cell row and best-match tracking
//
// start/busy take one item when start is high and busy low. a write item stores
// its colour and its result (index echoed, distance 0) comes with done in the
// next cycle; busy stays low, so writes can follow each other every cycle.
// a lookup raises busy until its result is registered; done is high for one
// cycle with result, and busy is already low in that cycle.
// the palette ram read port scans one entry a cycle from the top index down
// into a row of three distance cells (two stages each); a shade first gets
// its scale from the radix-4 divider.
// configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user
// must make them only while no lookup is running, and the block itself does
// not enforce this; there is no read-back.
// reset sets the configuration registers to their defaults and the controller
// idle; the palette itself holds nothing defined until entries are written.
// results cannot be held off: the receiver takes each one in its cycle.
module palette_shade_blend_nearest_color_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  psbnc_pkg::item_t                    item,
    output logic                                done,
    output psbnc_pkg::result_t                  result,
    input  logic                                cfg_we,
    input  logic [psbnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psbnc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import psbnc_pkg::*;

    // register defaults
    localparam logic [SHADE_W-1:0]  NUM_SHADES_RST = 9'd32;
    localparam logic [RATIO_W-1:0]  TRANS_RATIO_RST = 9'd170;
    localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST = 8'd30;
    localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 8'd59;
    localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 8'd11;

    state_t state_reg, state_next;

    logic [SHADE_W-1:0]  num_shades_reg;
    logic [RATIO_W-1:0]  trans_ratio_reg;
    logic [WEIGHT_W-1:0] red_weight_reg;
    logic [WEIGHT_W-1:0] green_weight_reg;
    logic [WEIGHT_W-1:0] blue_weight_reg;
    logic [WEIGHT_W-1:0] weight_vec [NUM_COMP];

    logic accept;

    action_t              act_reg;
    logic [IDX_W-1:0]     first_reg;
    logic [IDX_W-1:0]     second_reg;
    logic                 first_ok_reg;
    logic                 second_ok_reg;
    logic                 zero_scale_reg;
    comp_t [NUM_COMP-1:0] target_reg;
    logic [PAL_AW-1:0]    scan_reg;

    logic              feed_valid_reg;
    logic              feed_last_reg;
    logic [PAL_AW-1:0] feed_idx_reg;

    logic               ram_we;
    logic               ram_re_a;
    logic               ram_re_b;
    logic [PAL_AW-1:0]  ram_addr_a;
    logic [PAL_AW-1:0]  ram_addr_b;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata_a;
    logic [COLOR_W-1:0] ram_rdata_b;

    div_req_t  div_req;
    div_resp_t div_resp;

    comp_t [NUM_COMP-1:0]    src_a;
    comp_t [NUM_COMP-1:0]    src_b;
    comp_t [NUM_COMP-1:0]    mix_target;
    logic [SCALE_W-1:0]      scale;
    logic [RATIO_W-1:0]      ratio;
    logic [RATIO_W-1:0]      ratio_inv;
    logic [SHADE_PROD_W-1:0] shade_sum [NUM_COMP];
    logic [BLEND_PROD_W-1:0] blend_sum [NUM_COMP];

    flow_t             flow [NUM_COMP+1];
    flow_t             chain_end;
    logic              better;
    logic              have_reg;
    logic [DIST_W-1:0] best_reg;
    logic [PAL_AW-1:0] best_idx_reg;

    logic    done_reg, done_next;
    result_t result_reg, result_next;

    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_shades_reg   <= NUM_SHADES_RST;
            trans_ratio_reg  <= TRANS_RATIO_RST;
            red_weight_reg   <= RED_WEIGHT_RST;
            green_weight_reg <= GREEN_WEIGHT_RST;
            blue_weight_reg  <= BLUE_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_SHADES:   num_shades_reg   <= cfg_data[SHADE_W-1:0];
                REG_TRANS_RATIO:  trans_ratio_reg  <= cfg_data[RATIO_W-1:0];
                REG_RED_WEIGHT:   red_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT: green_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:  blue_weight_reg  <= cfg_data[WEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign weight_vec[0] = red_weight_reg;
    assign weight_vec[1] = green_weight_reg;
    assign weight_vec[2] = blue_weight_reg;

    // controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.action != ACT_WRITE)
                begin
                    if (item.action == ACT_RGB)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (act_reg == ACT_SHADE)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_MIX;
                end
            end
            ST_DIVIDE:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (scan_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (chain_end.valid && chain_end.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        busy       = 1'b1;
        ram_re_a   = 1'b0;
        ram_re_b   = 1'b0;
        ram_addr_a = first_reg[PAL_AW-1:0];
        ram_addr_b = second_reg[PAL_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_FETCH:
            begin
                ram_re_a = 1'b1;
                ram_re_b = 1'b1;
            end
            ST_SEARCH:
            begin
                ram_re_a   = 1'b1;
                ram_addr_a = scan_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // palette store
    assign ram_we    = accept && item.action == ACT_WRITE
                       && int'(item.first_color) < PAL_ENTRIES;
    assign ram_wdata = {item.red, item.green, item.blue};

    psbnc_ram #(
        .DEPTH (PAL_ENTRIES),
        .WIDTH (COLOR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (item.first_color[PAL_AW-1:0]),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_addr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_addr_b),
        .rdata_b (ram_rdata_b)
    );

    // shade scale divider
    assign div_req.start = accept && item.action == ACT_SHADE;
    assign div_req.numer = num_shades_reg - SHADE_W'(item.shade);
    assign div_req.denom = num_shades_reg;

    psbnc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // target colour from shade or blend
    always_comb
    begin
        scale     = zero_scale_reg ? '0 : div_resp.quot;
        ratio     = (trans_ratio_reg > RATIO_W'(BLEND_ONE)) ? RATIO_W'(BLEND_ONE)
                                                             : trans_ratio_reg;
        ratio_inv = RATIO_W'(BLEND_ONE) - ratio;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            src_a[k] = first_ok_reg
                       ? ram_rdata_a[(NUM_COMP-1-k)*COMP_W +: COMP_W] : '0;
            src_b[k] = second_ok_reg
                       ? ram_rdata_b[(NUM_COMP-1-k)*COMP_W +: COMP_W] : '0;
            shade_sum[k] = SHADE_PROD_W'(src_a[k]) * SHADE_PROD_W'(scale)
                           + SHADE_PROD_W'(SHADE_ROUND);
            blend_sum[k] = BLEND_PROD_W'(src_a[k]) * BLEND_PROD_W'(ratio_inv)
                           + BLEND_PROD_W'(src_b[k]) * BLEND_PROD_W'(ratio)
                           + BLEND_PROD_W'(BLEND_HALF);
            if (act_reg == ACT_SHADE)
            begin
                mix_target[k] = shade_sum[k][SCALE_FRAC +: COMP_W];
            end
            else
            begin
                mix_target[k] = blend_sum[k][BLEND_FRAC +: COMP_W];
            end
        end
    end

    // item latch, target and scan address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= item.action;
            first_reg      <= item.first_color;
            second_reg     <= item.second_color;
            first_ok_reg   <= int'(item.first_color) < PAL_ENTRIES;
            second_ok_reg  <= int'(item.second_color) < PAL_ENTRIES;
            zero_scale_reg <= (num_shades_reg == '0)
                              || ({1'b0, item.shade} >= num_shades_reg);
            target_reg[0]  <= item.red;
            target_reg[1]  <= item.green;
            target_reg[2]  <= item.blue;
            scan_reg       <= PAL_AW'(PAL_ENTRIES - 1);
        end
        else if (state_reg == ST_MIX)
        begin
            target_reg <= mix_target;
            scan_reg   <= PAL_AW'(PAL_ENTRIES - 1);
        end
        else if (state_reg == ST_SEARCH)
        begin
            scan_reg <= scan_reg - 1'b1;
        end
    end

    // feed tags line up with the registered ram data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_valid_reg <= 1'b0;
            feed_last_reg  <= 1'b0;
        end
        else
        begin
            feed_valid_reg <= state_reg == ST_SEARCH;
            feed_last_reg  <= state_reg == ST_SEARCH && scan_reg == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_idx_reg <= scan_reg;
    end

    always_comb
    begin
        flow[0].valid = feed_valid_reg;
        flow[0].last  = feed_last_reg;
        flow[0].index = feed_idx_reg;
        flow[0].sum   = '0;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            flow[0].comps[k] = ram_rdata_a[(NUM_COMP-1-k)*COMP_W +: COMP_W];
        end
    end

    // row of distance cells
    for (genvar g = 0; g < NUM_COMP; g++)
    begin : g_cell
        psbnc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tgt      (target_reg[g]),
            .weight   (weight_vec[g]),
            .flow_in  (flow[g]),
            .flow_out (flow[g+1])
        );
    end

    assign chain_end = flow[NUM_COMP];
    assign better    = !have_reg || (chain_end.sum < best_reg);

    // best match, strictly nearer wins so ties keep the higher index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (accept)
        begin
            have_reg <= 1'b0;
        end
        else if (chain_end.valid)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_end.valid && better)
        begin
            best_reg     <= chain_end.sum;
            best_idx_reg <= chain_end.index;
        end
    end

    // result register
    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        if (accept && item.action == ACT_WRITE)
        begin
            done_next                 = 1'b1;
            result_next.done_action   = ACT_WRITE;
            result_next.nearest_index = item.first_color;
            result_next.best_distance = '0;
        end
        else if (chain_end.valid && chain_end.last)
        begin
            done_next                 = 1'b1;
            result_next.done_action   = act_reg;
            result_next.nearest_index = IDX_W'(better ? chain_end.index : best_idx_reg);
            result_next.best_distance = better ? chain_end.sum : best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a result never shows while a lookup still holds the block
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted write answers in the next cycle
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action == ACT_WRITE)
        |=> (done && result.done_action == ACT_WRITE))
        else $error("write item without its result");

    // scored entries only leave the cell row during a scan
    a_row_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_end.valid |-> (state_reg == ST_SEARCH || state_reg == ST_DRAIN))
        else $error("cell row output outside a scan");

    // the divider only finishes while the controller waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide wait");
`endif

endmodule
